// File: sv/assert_macros.svh
// Assertion macros used by the page queue core RTL.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/mlpq_pkg.sv
// Types and fixed field widths of the multi-list page queue.
// No dependencies; used by the core, the checker and the testbench top.
package mlpq_pkg;

   localparam int OP_W       = 3;
   localparam int LIST_ID_W  = 3;
   localparam int PAGE_ID_W  = 10;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef enum logic [OP_W-1:0] {
      OP_ENQ    = 3'd0,
      OP_DEQ    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_MERGE  = 3'd3,
      OP_NEXT   = 3'd4,
      OP_PREV   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_LINKED = 2'd2,
      ST_NOT_IN = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_EXEC,
      S_ENQ2,
      S_MWALK,
      S_MSTEP,
      S_MLINK,
      S_MCLR,
      S_WALK,
      S_WLOAD,
      S_RESP
   } state_type;

endpackage

// File: sv/mlpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the per-page link and home stores.
module mlpq_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/mlpq_list_table.sv
// Per-list newest, oldest and size registers with one read and one write.
// Depends on nothing but its parameters; instanced by the core.
module mlpq_list_table #(
   parameter int PAGE_SLOTS = 1024,
   parameter int LIST_COUNT = 8,
   localparam int PW = $clog2(PAGE_SLOTS + 1),
   localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [LW-1:0] rd_idx,
   output logic [PW-1:0] rd_newest,
   output logic [PW-1:0] rd_oldest,
   output logic [PW-1:0] rd_size,
   input  logic          wr_en,
   input  logic [LW-1:0] wr_idx,
   input  logic [PW-1:0] wr_newest,
   input  logic [PW-1:0] wr_oldest,
   input  logic [PW-1:0] wr_size
);

   localparam logic [PW-1:0] NIL = PW'(PAGE_SLOTS);

   logic [PW-1:0] newest_ff [LIST_COUNT];
   logic [PW-1:0] oldest_ff [LIST_COUNT];
   logic [PW-1:0] size_ff   [LIST_COUNT];
   logic          rd_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIST_COUNT; i++) begin
            newest_ff[i] <= NIL;
            oldest_ff[i] <= NIL;
            size_ff[i]   <= '0;
         end
      end else if (wr_en) begin
         newest_ff[wr_idx] <= wr_newest;
         oldest_ff[wr_idx] <= wr_oldest;
         size_ff[wr_idx]   <= wr_size;
      end
   end

   // an index beyond the last list reads as an empty list
   assign rd_ok     = int'(rd_idx) < LIST_COUNT;
   assign rd_newest = rd_ok ? newest_ff[rd_idx] : NIL;
   assign rd_oldest = rd_ok ? oldest_ff[rd_idx] : NIL;
   assign rd_size   = rd_ok ? size_ff[rd_idx] : '0;

endmodule

// File: sv/multi_list_page_queue_core.sv
// Top level of the multi-list page queue: sequencer around the link stores.
// Depends on mlpq_pkg, mlpq_ram, mlpq_list_table and assert_macros.svh.
//
//  channel   dir  handshake                 payload
//  req_*     in   req_tvalid / req_tready   tdata: op, list_id, other_list, page_id
//                                           tuser: page_given
//  rsp_*     out  rsp_tvalid / rsp_tready   tdata: page_out, status, list_count
//                                           tuser: page_out_valid
//  csr_*     in   csr_wr_en                 csr_wr_data: walk_across_lists
//
// Most operations pass through accept, decode with memory read, execute, reply.
// Merge walks the moved pages (home relabel walks the link RAM), then links and clears the lists.
// A walk passes through S_WALK and S_WLOAD for each further list; one item in work at a time.
// After reset the home RAM is cleared before req_tready rises.
// A result waiting on rsp_tready holds the sequencer in its reply state.
`include "assert_macros.svh"

module multi_list_page_queue_core #(
   parameter int PAGE_SLOTS = 1024,
   parameter int LIST_COUNT = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] op, [5:3] list_id, [8:6] other_list, [18:9] page_id, rest zero
   input  logic [mlpq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] page_given
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [9:0] page_out, [11:10] status, [22:12] list_count, [23] zero
   output logic [mlpq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [0] page_out_valid
   output logic                              rsp_tuser,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data
);

   localparam int AW = $clog2(PAGE_SLOTS);
   localparam int PW = $clog2(PAGE_SLOTS + 1);
   localparam int LW = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
   localparam int HW = $clog2(LIST_COUNT + 1);
   localparam logic [PW-1:0] NIL     = PW'(PAGE_SLOTS);
   localparam logic [HW-1:0] NO_HOME = HW'(LIST_COUNT);

   mlpq_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 walk_en_ff;
   mlpq_pkg::op_type     op_ff;
   logic [2:0]           lid_ff, oth_ff;
   logic [9:0]           pg_ff;
   logic                 given_ff;
   logic [PW-1:0]        res_ff, res_in;
   mlpq_pkg::status_type status_ff, status_in;
   logic [PW-1:0]        cur_ff, cur_in;
   logic [LW-1:0]        wlst_ff, wlst_in;
   logic [PW-1:0]        m_newest_ff, m_newest_in;
   logic [PW-1:0]        m_oldest_ff, m_oldest_in;
   logic [PW-1:0]        m_size_ff, m_size_in;
   logic                 rsp_valid_ff;
   logic [mlpq_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                 rsp_user_ff;

   logic                 req_fire, out_load, fwd;
   logic                 lid_ok, oth_ok, pg_ok, decode_err;
   mlpq_pkg::status_type decode_status;
   logic [LW-1:0]        lid_idx, oth_idx;
   logic [AW-1:0]        pg_addr;
   logic [PW-1:0]        pg_ptr;
   logic [HW-1:0]        lid_home;
   logic                 walk_end;

   logic                 home_we, n2o_we, o2n_we;
   logic [AW-1:0]        home_waddr, n2o_waddr, o2n_waddr;
   logic [AW-1:0]        home_raddr, n2o_raddr, o2n_raddr;
   logic [HW-1:0]        home_wdata, home_rdata;
   logic [PW-1:0]        n2o_wdata, n2o_rdata, o2n_wdata, o2n_rdata;

   logic [LW-1:0]        lt_rd_idx, lt_wr_idx;
   logic [PW-1:0]        lt_newest, lt_oldest, lt_size;
   logic                 lt_we;
   logic [PW-1:0]        lt_wr_newest, lt_wr_oldest, lt_wr_size;

   mlpq_ram #(.WIDTH(HW), .DEPTH(PAGE_SLOTS)) u_home_ram (
      .clock  (clock),
      .wr_en  (home_we),
      .wr_addr(home_waddr),
      .wr_data(home_wdata),
      .rd_addr(home_raddr),
      .rd_data(home_rdata)
   );

   mlpq_ram #(.WIDTH(PW), .DEPTH(PAGE_SLOTS)) u_n2o_ram (
      .clock  (clock),
      .wr_en  (n2o_we),
      .wr_addr(n2o_waddr),
      .wr_data(n2o_wdata),
      .rd_addr(n2o_raddr),
      .rd_data(n2o_rdata)
   );

   mlpq_ram #(.WIDTH(PW), .DEPTH(PAGE_SLOTS)) u_o2n_ram (
      .clock  (clock),
      .wr_en  (o2n_we),
      .wr_addr(o2n_waddr),
      .wr_data(o2n_wdata),
      .rd_addr(o2n_raddr),
      .rd_data(o2n_rdata)
   );

   mlpq_list_table #(.PAGE_SLOTS(PAGE_SLOTS), .LIST_COUNT(LIST_COUNT)) u_list_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (lt_rd_idx),
      .rd_newest(lt_newest),
      .rd_oldest(lt_oldest),
      .rd_size  (lt_size),
      .wr_en    (lt_we),
      .wr_idx   (lt_wr_idx),
      .wr_newest(lt_wr_newest),
      .wr_oldest(lt_wr_oldest),
      .wr_size  (lt_wr_size)
   );

   assign req_tready = (state_ff == mlpq_pkg::S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_load   = (state_ff == mlpq_pkg::S_RESP) && (!rsp_valid_ff || rsp_tready);
   assign fwd        = (op_ff == mlpq_pkg::OP_NEXT);

   assign lid_ok   = int'(lid_ff) < LIST_COUNT;
   assign oth_ok   = int'(oth_ff) < LIST_COUNT;
   assign pg_ok    = int'(pg_ff) < PAGE_SLOTS;
   assign lid_idx  = LW'(lid_ff);
   assign oth_idx  = LW'(oth_ff);
   assign pg_addr  = AW'(pg_ff);
   assign pg_ptr   = PW'(pg_ff);
   assign lid_home = HW'(lid_ff);
   assign walk_end = fwd ? (wlst_ff == '0) : (wlst_ff == LW'(LIST_COUNT - 1));

   always_comb begin
      decode_err    = 1'b0;
      decode_status = mlpq_pkg::ST_OK;
      if (!lid_ok || (op_ff == mlpq_pkg::OP_MERGE && !oth_ok)) begin
         decode_err    = 1'b1;
         decode_status = mlpq_pkg::ST_EMPTY;
      end else if (!pg_ok && ((op_ff inside {mlpq_pkg::OP_ENQ, mlpq_pkg::OP_REMOVE}) ||
                   ((op_ff inside {mlpq_pkg::OP_NEXT, mlpq_pkg::OP_PREV}) && given_ff))) begin
         decode_err    = 1'b1;
         decode_status = mlpq_pkg::ST_NOT_IN;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mlpq_pkg::S_CLEAR: begin
            if (clr_ff == AW'(PAGE_SLOTS - 1)) begin
               state_in = mlpq_pkg::S_IDLE;
            end
         end
         mlpq_pkg::S_IDLE: begin
            if (req_fire) begin
               state_in = mlpq_pkg::S_DECODE;
            end
         end
         mlpq_pkg::S_DECODE: begin
            state_in = decode_err ? mlpq_pkg::S_RESP : mlpq_pkg::S_EXEC;
         end
         mlpq_pkg::S_EXEC: begin
            state_in = mlpq_pkg::S_RESP;
            case (op_ff)
               mlpq_pkg::OP_ENQ: begin
                  if (home_rdata == NO_HOME && lt_newest != NIL) begin
                     state_in = mlpq_pkg::S_ENQ2;
                  end
               end
               mlpq_pkg::OP_MERGE: begin
                  if (oth_ff != lid_ff) begin
                     state_in = mlpq_pkg::S_MWALK;
                  end
               end
               mlpq_pkg::OP_NEXT, mlpq_pkg::OP_PREV: begin
                  if (!given_ff) begin
                     state_in = mlpq_pkg::S_WALK;
                  end else if (walk_en_ff) begin
                     if (home_rdata != NO_HOME) begin
                        state_in = mlpq_pkg::S_WALK;
                     end
                  end else if (home_rdata == lid_home) begin
                     state_in = mlpq_pkg::S_WALK;
                  end
               end
               default: state_in = mlpq_pkg::S_RESP;
            endcase
         end
         mlpq_pkg::S_ENQ2:  state_in = mlpq_pkg::S_RESP;
         mlpq_pkg::S_MWALK: begin
            state_in = (cur_ff == NIL) ? mlpq_pkg::S_MLINK : mlpq_pkg::S_MSTEP;
         end
         mlpq_pkg::S_MSTEP: state_in = mlpq_pkg::S_MWALK;
         mlpq_pkg::S_MLINK: state_in = mlpq_pkg::S_MCLR;
         mlpq_pkg::S_MCLR:  state_in = mlpq_pkg::S_RESP;
         mlpq_pkg::S_WALK: begin
            if (cur_ff != NIL || !walk_en_ff || walk_end) begin
               state_in = mlpq_pkg::S_RESP;
            end else begin
               state_in = mlpq_pkg::S_WLOAD;
            end
         end
         mlpq_pkg::S_WLOAD: state_in = mlpq_pkg::S_WALK;
         mlpq_pkg::S_RESP: begin
            if (out_load) begin
               state_in = mlpq_pkg::S_IDLE;
            end
         end
         default: state_in = mlpq_pkg::S_CLEAR;
      endcase
   end

   // datapath and memory control per state
   always_comb begin
      clr_in       = clr_ff;
      res_in       = res_ff;
      status_in    = status_ff;
      cur_in       = cur_ff;
      wlst_in      = wlst_ff;
      m_newest_in  = m_newest_ff;
      m_oldest_in  = m_oldest_ff;
      m_size_in    = m_size_ff;
      home_we      = 1'b0;
      home_waddr   = pg_addr;
      home_wdata   = NO_HOME;
      n2o_we       = 1'b0;
      n2o_waddr    = pg_addr;
      n2o_wdata    = NIL;
      o2n_we       = 1'b0;
      o2n_waddr    = pg_addr;
      o2n_wdata    = NIL;
      home_raddr   = pg_addr;
      n2o_raddr    = pg_addr;
      o2n_raddr    = pg_addr;
      lt_rd_idx    = lid_idx;
      lt_we        = 1'b0;
      lt_wr_idx    = lid_idx;
      lt_wr_newest = lt_newest;
      lt_wr_oldest = lt_oldest;
      lt_wr_size   = lt_size;
      case (state_ff)
         mlpq_pkg::S_CLEAR: begin
            home_we    = 1'b1;
            home_waddr = clr_ff;
            clr_in     = clr_ff + 1'b1;
         end
         mlpq_pkg::S_DECODE: begin
            status_in = decode_status;
            res_in    = NIL;
            if (op_ff == mlpq_pkg::OP_DEQ) begin
               o2n_raddr = AW'(lt_oldest);
            end
         end
         mlpq_pkg::S_EXEC: begin
            if (op_ff == mlpq_pkg::OP_MERGE) begin
               lt_rd_idx = oth_idx;
            end
            case (op_ff)
               mlpq_pkg::OP_ENQ: begin
                  if (home_rdata != NO_HOME) begin
                     status_in = mlpq_pkg::ST_LINKED;
                  end else begin
                     n2o_we       = 1'b1;
                     n2o_wdata    = lt_newest;
                     o2n_we       = 1'b1;
                     home_we      = 1'b1;
                     home_wdata   = lid_home;
                     lt_we        = 1'b1;
                     lt_wr_newest = pg_ptr;
                     lt_wr_oldest = (lt_newest == NIL) ? pg_ptr : lt_oldest;
                     lt_wr_size   = lt_size + 1'b1;
                     cur_in       = lt_newest;
                  end
               end
               mlpq_pkg::OP_DEQ: begin
                  if (lt_oldest == NIL) begin
                     status_in = mlpq_pkg::ST_EMPTY;
                  end else begin
                     n2o_we       = (o2n_rdata != NIL);
                     n2o_waddr    = AW'(o2n_rdata);
                     home_we      = 1'b1;
                     home_waddr   = AW'(lt_oldest);
                     lt_we        = 1'b1;
                     lt_wr_oldest = o2n_rdata;
                     lt_wr_newest = (o2n_rdata == NIL) ? NIL : lt_newest;
                     lt_wr_size   = lt_size - 1'b1;
                     res_in       = lt_oldest;
                  end
               end
               mlpq_pkg::OP_REMOVE: begin
                  if (lt_newest == NIL) begin
                     status_in = mlpq_pkg::ST_EMPTY;
                  end else if (home_rdata != lid_home) begin
                     status_in = mlpq_pkg::ST_NOT_IN;
                  end else begin
                     // bridge the older and newer neighbours over the page
                     o2n_we       = (n2o_rdata != NIL);
                     o2n_waddr    = AW'(n2o_rdata);
                     o2n_wdata    = o2n_rdata;
                     n2o_we       = (o2n_rdata != NIL);
                     n2o_waddr    = AW'(o2n_rdata);
                     n2o_wdata    = n2o_rdata;
                     home_we      = 1'b1;
                     lt_we        = 1'b1;
                     lt_wr_newest = (lt_newest == pg_ptr) ? n2o_rdata : lt_newest;
                     lt_wr_oldest = (lt_oldest == pg_ptr) ? o2n_rdata : lt_oldest;
                     lt_wr_size   = lt_size - 1'b1;
                  end
               end
               mlpq_pkg::OP_MERGE: begin
                  m_newest_in = lt_newest;
                  m_oldest_in = lt_oldest;
                  m_size_in   = lt_size;
                  cur_in      = lt_newest;
               end
               mlpq_pkg::OP_NEXT, mlpq_pkg::OP_PREV: begin
                  wlst_in = lid_idx;
                  if (!given_ff) begin
                     cur_in = fwd ? lt_oldest : lt_newest;
                  end else if (walk_en_ff) begin
                     if (home_rdata == NO_HOME) begin
                        status_in = mlpq_pkg::ST_NOT_IN;
                     end else begin
                        wlst_in = LW'(home_rdata);
                        cur_in  = fwd ? o2n_rdata : n2o_rdata;
                     end
                  end else if (home_rdata != lid_home) begin
                     status_in = mlpq_pkg::ST_NOT_IN;
                  end else begin
                     cur_in = fwd ? o2n_rdata : n2o_rdata;
                  end
               end
               default: status_in = mlpq_pkg::ST_OK;
            endcase
         end
         mlpq_pkg::S_ENQ2: begin
            o2n_we    = 1'b1;
            o2n_waddr = AW'(cur_ff);
            o2n_wdata = pg_ptr;
         end
         mlpq_pkg::S_MWALK: begin
            // relabel one moved page and fetch its older neighbour
            if (cur_ff != NIL) begin
               home_we    = 1'b1;
               home_waddr = AW'(cur_ff);
               home_wdata = lid_home;
            end
            n2o_raddr = AW'(cur_ff);
         end
         mlpq_pkg::S_MSTEP: begin
            cur_in = n2o_rdata;
         end
         mlpq_pkg::S_MLINK: begin
            n2o_we       = (lt_oldest != NIL);
            n2o_waddr    = AW'(lt_oldest);
            n2o_wdata    = m_newest_ff;
            o2n_we       = (m_newest_ff != NIL);
            o2n_waddr    = AW'(m_newest_ff);
            o2n_wdata    = lt_oldest;
            lt_we        = 1'b1;
            lt_wr_newest = (lt_newest == NIL) ? m_newest_ff : lt_newest;
            lt_wr_oldest = (m_oldest_ff != NIL) ? m_oldest_ff : lt_oldest;
            lt_wr_size   = lt_size + m_size_ff;
         end
         mlpq_pkg::S_MCLR: begin
            lt_we        = 1'b1;
            lt_wr_idx    = oth_idx;
            lt_wr_newest = NIL;
            lt_wr_oldest = NIL;
            lt_wr_size   = '0;
         end
         mlpq_pkg::S_WALK: begin
            if (cur_ff != NIL) begin
               res_in    = cur_ff;
               status_in = mlpq_pkg::ST_OK;
            end else if (!walk_en_ff || walk_end) begin
               status_in = mlpq_pkg::ST_EMPTY;
            end else begin
               wlst_in = fwd ? (wlst_ff - 1'b1) : (wlst_ff + 1'b1);
            end
         end
         mlpq_pkg::S_WLOAD: begin
            lt_rd_idx = wlst_ff;
            cur_in    = fwd ? lt_oldest : lt_newest;
         end
         default: clr_in = clr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlpq_pkg::S_CLEAR;
         clr_ff       <= '0;
         walk_en_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_wr_en) begin
            walk_en_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= mlpq_pkg::op_type'(req_tdata[2:0]);
         lid_ff   <= req_tdata[5:3];
         oth_ff   <= req_tdata[8:6];
         pg_ff    <= req_tdata[18:9];
         given_ff <= req_tuser;
      end
      res_ff      <= res_in;
      status_ff   <= status_in;
      cur_ff      <= cur_in;
      wlst_ff     <= wlst_in;
      m_newest_ff <= m_newest_in;
      m_oldest_ff <= m_oldest_in;
      m_size_ff   <= m_size_in;
      if (out_load) begin
         rsp_data_ff <= {1'b0,
                         lid_ok ? mlpq_pkg::COUNT_W'(lt_size) : mlpq_pkg::COUNT_W'(0),
                         status_ff,
                         (res_ff != NIL) ? mlpq_pkg::PAGE_ID_W'(res_ff)
                                         : mlpq_pkg::PAGE_ID_W'(0)};
         rsp_user_ff <= (res_ff != NIL);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `ASSERT_NEXT(a_one_item, clock, reset, req_fire, !req_tready, "second word taken while busy")
   `ASSERT_IMPL(a_rsp_src, clock, reset, $rose(rsp_tvalid), $past(state_ff) == mlpq_pkg::S_RESP, "result word not from reply state")
   `ASSERT_IMPL(a_deq_page, clock, reset, out_load && op_ff == mlpq_pkg::OP_DEQ && status_ff == mlpq_pkg::ST_OK, res_ff != NIL, "good dequeue without a page")
   `ASSERT_IMPL(a_clear_quiet, clock, reset, state_ff == mlpq_pkg::S_CLEAR, !rsp_tvalid, "result during clearing pass")

endmodule

// File: tb/sv/multi_list_page_queue_checker.sv
// Checker for the multi-list page queue: watches both channels and the CSR write,
// keeps its own copy of the lists and compares every reply word. Depends on mlpq_pkg.
module multi_list_page_queue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        finish_check,
   output int          fail_count,
   output int          replies_pending
);

   localparam int SLOTS = 1024;
   localparam int LISTS = 8;
   localparam logic [10:0] NIL = 11'd1024;
   localparam logic [3:0] NO_HOME = 4'd8;

   typedef struct packed {
      logic [9:0]           page;
      logic                 page_valid;
      mlpq_pkg::status_type status;
      logic [10:0]          count;
   } reply_t;

   logic [10:0] older_link [SLOTS];  // newer to older
   logic [10:0] newer_link [SLOTS];  // older to newer
   logic [3:0]  home [SLOTS];
   logic [10:0] newest [LISTS];
   logic [10:0] oldest [LISTS];
   logic [10:0] size [LISTS];
   logic        walk_across;
   reply_t      expected_replies [$];

   assign replies_pending = expected_replies.size();

   function automatic void clear_page(input int p);
      older_link[p] = NIL;
      newer_link[p] = NIL;
      home[p] = NO_HOME;
   endfunction

   function automatic reply_t apply_op(input mlpq_pkg::op_type op, input int lid,
                                       input int oth, input int pg, input logic given);
      reply_t r;
      logic [10:0] p, q, n;
      int lst;
      logic ok;
      r = '0;
      r.status = mlpq_pkg::ST_OK;
      p = NIL;
      case (op)
         mlpq_pkg::OP_ENQ: begin
            if (home[pg] != NO_HOME) r.status = mlpq_pkg::ST_LINKED;
            else begin
               q = newest[lid];
               older_link[pg] = q;
               newer_link[pg] = NIL;
               if (q != NIL) newer_link[q] = 11'(pg);
               else oldest[lid] = 11'(pg);
               newest[lid] = 11'(pg);
               home[pg] = 4'(lid);
               size[lid]++;
            end
         end
         mlpq_pkg::OP_DEQ: begin
            p = oldest[lid];
            if (p == NIL) r.status = mlpq_pkg::ST_EMPTY;
            else begin
               q = newer_link[p];
               oldest[lid] = q;
               if (q != NIL) older_link[q] = NIL;
               else newest[lid] = NIL;
               clear_page(p);
               size[lid]--;
            end
         end
         mlpq_pkg::OP_REMOVE: begin
            if (newest[lid] == NIL) r.status = mlpq_pkg::ST_EMPTY;
            else if (home[pg] != lid) r.status = mlpq_pkg::ST_NOT_IN;
            else begin
               q = older_link[pg];
               n = newer_link[pg];
               if (newest[lid] == pg) newest[lid] = q;
               if (oldest[lid] == pg) oldest[lid] = n;
               if (q != NIL) newer_link[q] = n;
               if (n != NIL) older_link[n] = q;
               clear_page(pg);
               size[lid]--;
            end
         end
         mlpq_pkg::OP_MERGE: begin
            if (oth != lid) begin
               for (q = newest[oth]; q != NIL; q = older_link[q]) home[q] = 4'(lid);
               if (oldest[lid] != NIL) older_link[oldest[lid]] = newest[oth];
               if (newest[oth] != NIL) newer_link[newest[oth]] = oldest[lid];
               if (newest[lid] == NIL) newest[lid] = newest[oth];
               if (oldest[oth] != NIL) oldest[lid] = oldest[oth];
               size[lid] += size[oth];
               size[oth] = '0;
               newest[oth] = NIL;
               oldest[oth] = NIL;
            end
         end
         mlpq_pkg::OP_NEXT, mlpq_pkg::OP_PREV: begin
            ok = 1'b1;
            lst = lid;
            if (!given) p = (op == mlpq_pkg::OP_NEXT) ? oldest[lst] : newest[lst];
            else if (walk_across) begin
               if (home[pg] == NO_HOME) ok = 1'b0;
               else begin
                  lst = home[pg];
                  p = (op == mlpq_pkg::OP_NEXT) ? newer_link[pg] : older_link[pg];
               end
            end else if (home[pg] != lid) ok = 1'b0;
            else p = (op == mlpq_pkg::OP_NEXT) ? newer_link[pg] : older_link[pg];
            if (!ok) begin
               r.status = mlpq_pkg::ST_NOT_IN;
               p = NIL;
            end else begin
               // carry on into neighbouring lists
               if (walk_across)
                  while (p == NIL) begin
                     if (op == mlpq_pkg::OP_NEXT) begin
                        if (lst == 0) break;
                        lst--;
                        p = oldest[lst];
                     end else begin
                        if (lst + 1 >= LISTS) break;
                        lst++;
                        p = newest[lst];
                     end
                  end
               if (p == NIL) r.status = mlpq_pkg::ST_EMPTY;
            end
         end
         default: ;
      endcase
      if (op == mlpq_pkg::OP_DEQ && r.status != mlpq_pkg::ST_OK) p = NIL;
      if (op inside {mlpq_pkg::OP_DEQ, mlpq_pkg::OP_NEXT, mlpq_pkg::OP_PREV} && p != NIL) begin
         r.page = p[9:0];
         r.page_valid = 1'b1;
      end
      r.count = size[lid];
      return r;
   endfunction

   reply_t got, want;

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) clear_page(i);
         for (int i = 0; i < LISTS; i++) begin
            newest[i] = NIL;
            oldest[i] = NIL;
            size[i] = '0;
         end
         walk_across = 1'b1;
         expected_replies.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) walk_across = csr_wr_data;
         if (req_tvalid && req_tready)
            expected_replies.push_back(apply_op(mlpq_pkg::op_type'(req_tdata[2:0]),
               req_tdata[5:3], req_tdata[8:6], req_tdata[18:9], req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got.page = rsp_tdata[9:0];
            got.status = mlpq_pkg::status_type'(rsp_tdata[11:10]);
            got.count = rsp_tdata[22:12];
            got.page_valid = rsp_tuser;
            if (expected_replies.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected reply word %h", rsp_tdata);
            end else begin
               want = expected_replies.pop_front();
               if (got != want || rsp_tdata[23] !== 1'b0) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("reply mismatch: exp page %0d/%0b st %0d cnt %0d, got %0d/%0b st %0d cnt %0d",
                        want.page, want.page_valid, want.status, want.count,
                        got.page, got.page_valid, got.status, got.count);
               end
            end
         end
         if (finish_check && expected_replies.size() != 0) begin
            fail_count += expected_replies.size();
            expected_replies.delete();
         end
      end
   end
endmodule

// File: tb/sv/multi_list_page_queue_core_test.sv
// Top of the page queue testbench: clock, reset, request stimulus, receiver stalls, verdict.
// Depends on mlpq_pkg, multi_list_page_queue_core and multi_list_page_queue_checker.
module multi_list_page_queue_core_test;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 0;
   logic        csr_wr_data = 0;
   logic        finish_check = 0;
   logic        hold_off = 0;
   int          fail_count, replies_pending;
   int          idle_cycles = 0;
   logic [9:0]  recent_pages [$];

   localparam int IDLE_LIMIT = 20000;

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   multi_list_page_queue_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   multi_list_page_queue_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .finish_check(finish_check),
      .fail_count(fail_count), .replies_pending(replies_pending)
   );

   // receiver stall pattern; long hold-off on request
   always @(posedge clock) begin
      if (hold_off) rsp_tready <= 0;
      else if ($urandom_range(0, 3) == 0) rsp_tready <= 1'($urandom_range(0, 1));
      else rsp_tready <= 1;
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   int burst_left = 0;

   // hold tvalid high within a burst; drop it when the burst ends
   task automatic send_word(input mlpq_pkg::op_type op, input int lid, input int oth,
                            input int pg, input logic given);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= {5'd0, pg[9:0], oth[2:0], lid[2:0], op};
      req_tuser <= given;
      do @(posedge clock); while (!req_tready);
      if (burst_left == 0) req_tvalid <= 0;
   endtask

   task automatic end_burst();
      if (burst_left != 0) begin
         req_tvalid <= 0;
         burst_left = 0;
      end
   endtask

   function automatic int pick_page();
      if (recent_pages.size() > 0 && $urandom_range(0, 2) != 0)
         return recent_pages[$urandom_range(0, recent_pages.size() - 1)];
      return $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
   endfunction

   task automatic random_item();
      int sel, pg;
      mlpq_pkg::op_type op;
      sel = $urandom_range(0, 99);
      pg = pick_page();
      if (sel < 35) op = mlpq_pkg::OP_ENQ;
      else if (sel < 50) op = mlpq_pkg::OP_DEQ;
      else if (sel < 62) op = mlpq_pkg::OP_REMOVE;
      else if (sel < 67) op = mlpq_pkg::OP_MERGE;
      else if (sel < 84) op = mlpq_pkg::OP_NEXT;
      else op = mlpq_pkg::OP_PREV;
      if (op == mlpq_pkg::OP_ENQ) begin
         recent_pages.push_back(pg[9:0]);
         if (recent_pages.size() > 40) void'(recent_pages.pop_front());
      end
      send_word(op, $urandom_range(0, 7), $urandom_range(0, 7), pg,
                1'($urandom_range(0, 1)));
   endtask

   task automatic drain_and_write(input logic value);
      end_burst();
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      // directed: extremes, every op, misuse cases
      send_word(mlpq_pkg::OP_DEQ, 0, 0, 0, 0);
      send_word(mlpq_pkg::OP_REMOVE, 7, 0, 5, 1);
      send_word(mlpq_pkg::OP_NEXT, 7, 0, 0, 0);
      send_word(mlpq_pkg::OP_PREV, 0, 0, 0, 0);
      send_word(mlpq_pkg::OP_ENQ, 0, 0, 0, 0);
      send_word(mlpq_pkg::OP_ENQ, 0, 0, 1023, 1);
      send_word(mlpq_pkg::OP_ENQ, 7, 0, 1023, 0);
      send_word(mlpq_pkg::OP_ENQ, 7, 0, 512, 0);
      send_word(mlpq_pkg::OP_ENQ, 3, 0, 341, 0);
      send_word(mlpq_pkg::OP_NEXT, 7, 0, 0, 0);
      send_word(mlpq_pkg::OP_PREV, 0, 0, 0, 0);
      send_word(mlpq_pkg::OP_NEXT, 0, 0, 1023, 1);
      send_word(mlpq_pkg::OP_PREV, 7, 0, 512, 1);
      send_word(mlpq_pkg::OP_NEXT, 0, 0, 77, 1);
      send_word(mlpq_pkg::OP_REMOVE, 3, 0, 0, 0);
      send_word(mlpq_pkg::OP_MERGE, 7, 7, 0, 0);
      send_word(mlpq_pkg::OP_MERGE, 0, 7, 0, 0);
      send_word(mlpq_pkg::OP_MERGE, 7, 3, 0, 0);
      send_word(mlpq_pkg::OP_DEQ, 0, 0, 0, 0);
      send_word(mlpq_pkg::OP_REMOVE, 0, 0, 1023, 1);
      send_word(mlpq_pkg::op_type'(3'd6), 2, 5, 9, 1);
      send_word(mlpq_pkg::op_type'(3'd7), 5, 2, 700, 0);
      drain_and_write(0);
      send_word(mlpq_pkg::OP_NEXT, 0, 0, 512, 1);
      send_word(mlpq_pkg::OP_PREV, 7, 0, 341, 1);
      send_word(mlpq_pkg::OP_NEXT, 7, 0, 0, 0);
      // receiver holds off while items keep coming
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         begin
            repeat (40) random_item();
            end_burst();
         end
      join
      for (int phase = 0; phase < 4; phase++) begin
         drain_and_write(phase[0]);
         repeat (410) random_item();
      end
      end_burst();
      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      finish_check <= 1;
      @(posedge clock);
      @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule

// File: files.f
+incdir+sv
sv/mlpq_pkg.sv
sv/mlpq_ram.sv
sv/mlpq_list_table.sv
sv/multi_list_page_queue_core.sv
tb/sv/multi_list_page_queue_checker.sv
tb/sv/multi_list_page_queue_core_test.sv
